>>> rtl/core/tca_pkg.sv
// Shared types and constants for the tilt-compensated attitude pipeline.
// No dependencies; used by the CORDIC cells and the top level.
`default_nettype none

package tca_pkg;

  // Internal angles are signed degrees scaled by 2^16.
  localparam int unsigned AngW    = 26;
  localparam int unsigned AtanLen = 24;

  typedef logic signed [AngW-1:0] ang_t;

  localparam ang_t ANG_180 = 26'sd11796480;
  localparam ang_t ANG_360 = 26'sd23592960;

  // CORDIC start value, the reciprocal of the gain of an unlimited number of stages in Q30.
  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

  // Output limits in 1/64 degree.
  localparam logic signed [15:0] MAX_TILT_OUT  = 16'sd5760;
  localparam logic signed [15:0] FULL_TURN_OUT = 16'sd23040;

  // atan(2^-i) in degrees * 2^16, rounded to nearest.
  localparam ang_t ATAN_TAB [AtanLen] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0
  };

endpackage

`default_nettype wire

>>> rtl/core/tilt_compensated_attitude.sv
// Tilt-compensated attitude and compass heading, fully pipelined: one sensor word
// (accelerometer and magnetometer vector) is taken every cycle and one result word
// leaves every cycle while the output is not stalled. The path runs through two
// 32-step square-root chains, three CORDIC chains (tilt vectoring, sine and cosine
// rotation, heading vectoring), three multiply stages and a 14-step square root
// for the off-vertical angle. The whole pipeline advances together; it holds only when
// a result waits at the output while the receiver stalls. Angles are in 1/64 degree.
// Depends on tca_pkg, tca_sqrt_cell and tca_cordic_cell.
`default_nettype none

module tilt_compensated_attitude #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  input  wire logic signed [15:0] accel_z_i,
  input  wire logic signed [15:0] mag_x_i,
  input  wire logic signed [15:0] mag_y_i,
  input  wire logic signed [15:0] mag_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [13:0]      roll_angle_o,
  output logic signed [13:0]      pitch_angle_o,
  output logic [14:0]             heading_angle_o,
  output logic [12:0]             tilt_from_vertical_o
);

  localparam int unsigned N   = CORDIC_STAGES;
  localparam int unsigned SqW = 64;
  localparam int unsigned SqN = SqW / 2;
  localparam int unsigned VW  = 36;
  localparam int unsigned RW  = 32;
  localparam int unsigned YW  = 54;
  localparam int unsigned TW  = 28;
  localparam int unsigned TN  = TW / 2;

  // Round half up from degrees * 2^16 to 1/64 degree.
  function automatic logic signed [15:0] to_out(tca_pkg::ang_t a);
    logic signed [tca_pkg::AngW:0] t;
    t = {a[tca_pkg::AngW-1], a} + 27'sd512;
    return t[tca_pkg::AngW-1:10];
  endfunction

  // Limit a tilt angle to plus or minus 90 degrees.
  function automatic logic signed [13:0] clamp_tilt(logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v > tca_pkg::MAX_TILT_OUT) r = tca_pkg::MAX_TILT_OUT;
    if (v < -tca_pkg::MAX_TILT_OUT) r = -tca_pkg::MAX_TILT_OUT;
    return r[13:0];
  endfunction

  logic en;
  logic out_valid_q;

  // The pipeline moves unless a result word is blocked at the output.
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------- squares
  logic               s1_valid_q;
  logic [31:0]        s1_sroll_q, s1_spitch_q;
  logic signed [15:0] s1_ax_q, s1_ay_q, s1_mx_q, s1_my_q, s1_mz_q;
  logic signed [31:0] ax_sq, ay_sq, az_sq;

  assign ax_sq = accel_x_i * accel_x_i;
  assign ay_sq = accel_y_i * accel_y_i;
  assign az_sq = accel_z_i * accel_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sroll_q  <= $unsigned(ax_sq) + $unsigned(az_sq);
      s1_spitch_q <= $unsigned(ay_sq) + $unsigned(az_sq);
      s1_ax_q     <= accel_x_i;
      s1_ay_q     <= accel_y_i;
      s1_mx_q     <= mag_x_i;
      s1_my_q     <= mag_y_i;
      s1_mz_q     <= mag_z_i;
    end
  end

  // ------------------------------------------------ denominator square roots
  logic           rs_v [SqN+1];
  logic [SqW-1:0] rs_rem [SqN+1];
  logic [SqW-1:0] rs_root [SqN+1];
  logic [63:0]    rs_side [SqN+1];
  logic           ps_v [SqN+1];
  logic [SqW-1:0] ps_rem [SqN+1];
  logic [SqW-1:0] ps_root [SqN+1];
  logic [15:0]    ps_side [SqN+1];

  assign rs_v[0]    = s1_valid_q;
  assign rs_rem[0]  = {s1_sroll_q, 32'd0};
  assign rs_root[0] = '0;
  assign rs_side[0] = {s1_ay_q, s1_mx_q, s1_my_q, s1_mz_q};
  assign ps_v[0]    = s1_valid_q;
  assign ps_rem[0]  = {s1_spitch_q, 32'd0};
  assign ps_root[0] = '0;
  assign ps_side[0] = s1_ax_q;

  for (genvar k = 0; k < SqN; k++) begin : g_den_sqrt
    tca_sqrt_cell #(.W(SqW), .SW(64), .STAGE(k)) u_roll (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(rs_v[k]), .rem_i(rs_rem[k]), .root_i(rs_root[k]), .side_i(rs_side[k]),
      .valid_o(rs_v[k+1]), .rem_o(rs_rem[k+1]), .root_o(rs_root[k+1]),
      .side_o(rs_side[k+1])
    );
    tca_sqrt_cell #(.W(SqW), .SW(16), .STAGE(k)) u_pitch (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(ps_v[k]), .rem_i(ps_rem[k]), .root_i(ps_root[k]), .side_i(ps_side[k]),
      .valid_o(ps_v[k+1]), .rem_o(ps_rem[k+1]), .root_o(ps_root[k+1]),
      .side_o(ps_side[k+1])
    );
  end

  // ------------------------------------------------ roll and pitch atan2
  logic signed [15:0] rs_ay;
  logic signed [16:0] nax;

  assign rs_ay = rs_side[SqN][63:48];
  assign nax   = -{ps_side[SqN][15], ps_side[SqN]};

  logic                 rv_v [N+1];
  logic signed [VW-1:0] rv_x [N+1];
  logic signed [VW-1:0] rv_y [N+1];
  tca_pkg::ang_t        rv_z [N+1];
  logic [48:0]          rv_side [N+1];
  logic                 pv_v [N+1];
  logic signed [VW-1:0] pv_x [N+1];
  logic signed [VW-1:0] pv_y [N+1];
  tca_pkg::ang_t        pv_z [N+1];
  logic [0:0]           pv_side [N+1];

  // Numerator scaled by 2^16 over a non-negative root; both zero means angle zero.
  assign rv_v[0]    = rs_v[SqN];
  assign rv_x[0]    = {{(VW-32){1'b0}}, rs_root[SqN][31:0]};
  assign rv_y[0]    = {{(VW-32){rs_ay[15]}}, rs_ay, 16'd0};
  assign rv_z[0]    = '0;
  assign rv_side[0] = {rs_side[SqN][47:0], (rs_root[SqN] == '0) && (rs_ay == '0)};
  assign pv_v[0]    = ps_v[SqN];
  assign pv_x[0]    = {{(VW-32){1'b0}}, ps_root[SqN][31:0]};
  assign pv_y[0]    = {{(VW-33){nax[16]}}, nax, 16'd0};
  assign pv_z[0]    = '0;
  assign pv_side[0] = (ps_root[SqN] == '0) && (nax == '0);

  for (genvar k = 0; k < N; k++) begin : g_tilt_vec
    tca_cordic_cell #(.XW(VW), .SW(49), .STAGE(k), .VECTOR(1'b1)) u_roll (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(rv_v[k]), .x_i(rv_x[k]), .y_i(rv_y[k]), .z_i(rv_z[k]), .side_i(rv_side[k]),
      .valid_o(rv_v[k+1]), .x_o(rv_x[k+1]), .y_o(rv_y[k+1]), .z_o(rv_z[k+1]),
      .side_o(rv_side[k+1])
    );
    tca_cordic_cell #(.XW(VW), .SW(1), .STAGE(k), .VECTOR(1'b1)) u_pitch (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(pv_v[k]), .x_i(pv_x[k]), .y_i(pv_y[k]), .z_i(pv_z[k]), .side_i(pv_side[k]),
      .valid_o(pv_v[k+1]), .x_o(pv_x[k+1]), .y_o(pv_y[k+1]), .z_o(pv_z[k+1]),
      .side_o(pv_side[k+1])
    );
  end

  // ------------------------------------------------ sine and cosine
  tca_pkg::ang_t      roll_z, pitch_z;
  logic signed [13:0] roll_out, pitch_out;

  assign roll_z    = rv_side[N][0] ? '0 : rv_z[N];
  assign pitch_z   = pv_side[N][0] ? '0 : pv_z[N];
  assign roll_out  = clamp_tilt(to_out(roll_z));
  assign pitch_out = clamp_tilt(to_out(pitch_z));

  logic                 rr_v [N+1];
  logic signed [RW-1:0] rr_x [N+1];
  logic signed [RW-1:0] rr_y [N+1];
  tca_pkg::ang_t        rr_z [N+1];
  logic [61:0]          rr_side [N+1];
  logic                 pr_v [N+1];
  logic signed [RW-1:0] pr_x [N+1];
  logic signed [RW-1:0] pr_y [N+1];
  tca_pkg::ang_t        pr_z [N+1];
  logic [13:0]          pr_side [N+1];

  assign rr_v[0]    = rv_v[N];
  assign rr_x[0]    = tca_pkg::GAIN_Q30;
  assign rr_y[0]    = '0;
  assign rr_z[0]    = roll_z;
  assign rr_side[0] = {rv_side[N][48:1], roll_out};
  assign pr_v[0]    = pv_v[N];
  assign pr_x[0]    = tca_pkg::GAIN_Q30;
  assign pr_y[0]    = '0;
  assign pr_z[0]    = pitch_z;
  assign pr_side[0] = pitch_out;

  for (genvar k = 0; k < N; k++) begin : g_sincos
    tca_cordic_cell #(.XW(RW), .SW(62), .STAGE(k), .VECTOR(1'b0)) u_roll (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(rr_v[k]), .x_i(rr_x[k]), .y_i(rr_y[k]), .z_i(rr_z[k]), .side_i(rr_side[k]),
      .valid_o(rr_v[k+1]), .x_o(rr_x[k+1]), .y_o(rr_y[k+1]), .z_o(rr_z[k+1]),
      .side_o(rr_side[k+1])
    );
    tca_cordic_cell #(.XW(RW), .SW(14), .STAGE(k), .VECTOR(1'b0)) u_pitch (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(pr_v[k]), .x_i(pr_x[k]), .y_i(pr_y[k]), .z_i(pr_z[k]), .side_i(pr_side[k]),
      .valid_o(pr_v[k+1]), .x_o(pr_x[k+1]), .y_o(pr_y[k+1]), .z_o(pr_z[k+1]),
      .side_o(pr_side[k+1])
    );
  end

  // ------------------------------------------------ tilt compensation products
  logic signed [RW-1:0] cr, sr, cp, sp;
  logic signed [15:0]   r_mx, r_my, r_mz;
  logic signed [63:0]   prod_ss, prod_sc;

  assign cr      = rr_x[N];
  assign sr      = rr_y[N];
  assign cp      = pr_x[N];
  assign sp      = pr_y[N];
  assign r_mx    = rr_side[N][61:46];
  assign r_my    = rr_side[N][45:30];
  assign r_mz    = rr_side[N][29:14];
  assign prod_ss = sr * sp;
  assign prod_sc = sr * cp;

  logic               m1_valid_q, m2_valid_q, m3_valid_q;
  logic signed [31:0] m1_t1_q, m1_t2_q, m1_cr_q;
  logic signed [47:0] m1_xc_q, m1_zs_q;
  logic signed [15:0] m1_mx_q, m1_my_q, m1_mz_q;
  logic signed [13:0] m1_roll_q, m1_pitch_q, m2_roll_q, m2_pitch_q, m3_roll_q, m3_pitch_q;
  logic signed [47:0] m2_a_q, m2_b_q, m2_c_q;
  logic signed [48:0] m2_xh_q, m3_xh_q;
  logic signed [49:0] m3_yh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
      m2_valid_q <= 1'b0;
      m3_valid_q <= 1'b0;
    end else if (en) begin
      m1_valid_q <= rr_v[N];
      m2_valid_q <= m1_valid_q;
      m3_valid_q <= m2_valid_q;
    end
  end

  // Roll sine products in Q30 and x terms, then y terms and the x sum, then the y sum.
  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_t1_q    <= prod_ss[61:30];
      m1_t2_q    <= prod_sc[61:30];
      m1_cr_q    <= cr;
      m1_xc_q    <= r_mx * cp;
      m1_zs_q    <= r_mz * sp;
      m1_mx_q    <= r_mx;
      m1_my_q    <= r_my;
      m1_mz_q    <= r_mz;
      m1_roll_q  <= rr_side[N][13:0];
      m1_pitch_q <= pr_side[N];

      m2_a_q     <= m1_mx_q * m1_t1_q;
      m2_b_q     <= m1_my_q * m1_cr_q;
      m2_c_q     <= m1_mz_q * m1_t2_q;
      m2_xh_q    <= {m1_xc_q[47], m1_xc_q} + {m1_zs_q[47], m1_zs_q};
      m2_roll_q  <= m1_roll_q;
      m2_pitch_q <= m1_pitch_q;

      m3_yh_q    <= {{2{m2_a_q[47]}}, m2_a_q} + {{2{m2_b_q[47]}}, m2_b_q}
                  - {{2{m2_c_q[47]}}, m2_c_q};
      m3_xh_q    <= m2_xh_q;
      m3_roll_q  <= m2_roll_q;
      m3_pitch_q <= m2_pitch_q;
    end
  end

  // ------------------------------------------------ heading atan2
  logic signed [YW-1:0] xh_ext, yh_ext;

  assign xh_ext = {{(YW-49){m3_xh_q[48]}}, m3_xh_q};
  assign yh_ext = {{(YW-50){m3_yh_q[49]}}, m3_yh_q};

  logic                 yv_v [N+1];
  logic signed [YW-1:0] yv_x [N+1];
  logic signed [YW-1:0] yv_y [N+1];
  tca_pkg::ang_t        yv_z [N+1];
  logic [28:0]          yv_side [N+1];
  logic signed [YW-1:0] yaw_x0, yaw_y0;
  tca_pkg::ang_t        yaw_z0;

  // A vector in the left half-plane is first turned by 180 degrees.
  always_comb begin
    if (m3_xh_q[48]) begin
      yaw_x0 = -xh_ext;
      yaw_y0 = -yh_ext;
      yaw_z0 = m3_yh_q[49] ? -tca_pkg::ANG_180 : tca_pkg::ANG_180;
    end else begin
      yaw_x0 = xh_ext;
      yaw_y0 = yh_ext;
      yaw_z0 = '0;
    end
  end

  assign yv_x[0]    = yaw_x0;
  assign yv_y[0]    = yaw_y0;
  assign yv_z[0]    = yaw_z0;
  assign yv_v[0]    = m3_valid_q;
  assign yv_side[0] = {m3_roll_q, m3_pitch_q, (m3_xh_q == '0) && (m3_yh_q == '0)};

  for (genvar k = 0; k < N; k++) begin : g_yaw_vec
    tca_cordic_cell #(.XW(YW), .SW(29), .STAGE(k), .VECTOR(1'b1)) u_yaw (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(yv_v[k]), .x_i(yv_x[k]), .y_i(yv_y[k]), .z_i(yv_z[k]), .side_i(yv_side[k]),
      .valid_o(yv_v[k+1]), .x_o(yv_x[k+1]), .y_o(yv_y[k+1]), .z_o(yv_z[k+1]),
      .side_o(yv_side[k+1])
    );
  end

  // ------------------------------------------------ heading wrap and tilt square
  tca_pkg::ang_t      yaw_z;
  logic signed [15:0] yaw_r;
  logic [14:0]        yaw_out;
  logic signed [13:0] f_roll_d, f_pitch_d;
  logic signed [27:0] roll_sq, pitch_sq;

  always_comb begin
    yaw_z = yv_side[N][0] ? '0 : yv_z[N];
    if (yaw_z[tca_pkg::AngW-1]) begin
      yaw_z = yaw_z + tca_pkg::ANG_360;
    end
    yaw_r = to_out(yaw_z);
    if (yaw_r >= tca_pkg::FULL_TURN_OUT) begin
      yaw_r = yaw_r - tca_pkg::FULL_TURN_OUT;
    end
    if (yaw_r[15]) begin
      yaw_r = '0;
    end
    yaw_out = yaw_r[14:0];
  end

  assign f_roll_d  = yv_side[N][28:15];
  assign f_pitch_d = yv_side[N][14:1];
  assign roll_sq   = f_roll_d * f_roll_d;
  assign pitch_sq  = f_pitch_d * f_pitch_d;

  logic               f_valid_q;
  logic signed [13:0] f_roll_q, f_pitch_q;
  logic [14:0]        f_yaw_q;
  logic [TW-1:0]      f_ss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= yv_v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_roll_q  <= f_roll_d;
      f_pitch_q <= f_pitch_d;
      f_yaw_q   <= yaw_out;
      f_ss_q    <= $unsigned(roll_sq) + $unsigned(pitch_sq);
    end
  end

  // ------------------------------------------------ off-vertical square root
  logic          ts_v [TN+1];
  logic [TW-1:0] ts_rem [TN+1];
  logic [TW-1:0] ts_root [TN+1];
  logic [42:0]   ts_side [TN+1];

  assign ts_v[0]    = f_valid_q;
  assign ts_rem[0]  = f_ss_q;
  assign ts_root[0] = '0;
  assign ts_side[0] = {f_roll_q, f_pitch_q, f_yaw_q};

  for (genvar k = 0; k < TN; k++) begin : g_tilt_sqrt
    tca_sqrt_cell #(.W(TW), .SW(43), .STAGE(k)) u_tilt (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(ts_v[k]), .rem_i(ts_rem[k]), .root_i(ts_root[k]), .side_i(ts_side[k]),
      .valid_o(ts_v[k+1]), .rem_o(ts_rem[k+1]), .root_o(ts_root[k+1]),
      .side_o(ts_side[k+1])
    );
  end

  // ------------------------------------------------ output register
  logic signed [13:0] roll_q, pitch_q;
  logic [14:0]        heading_q;
  logic [12:0]        tilt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ts_v[TN];
    end
  end

  // Round the root to nearest: bump it when the remainder exceeds the root.
  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q    <= ts_side[TN][42:29];
      pitch_q   <= ts_side[TN][28:15];
      heading_q <= ts_side[TN][14:0];
      tilt_q    <= ts_root[TN][12:0] + {12'd0, ts_rem[TN] > ts_root[TN]};
    end
  end

  assign out_valid_o          = out_valid_q;
  assign roll_angle_o         = roll_q;
  assign pitch_angle_o        = pitch_q;
  assign heading_angle_o      = heading_q;
  assign tilt_from_vertical_o = tilt_q;

  // ------------------------------------------------ assertions
  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output word is not blocked");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_angle_o < 15'd23040))
    else $error("heading word outside a full turn");

  a_tilt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((roll_angle_o >= -14'sd5760) && (roll_angle_o <= 14'sd5760)
                     && (pitch_angle_o >= -14'sd5760) && (pitch_angle_o <= 14'sd5760)))
    else $error("roll or pitch word beyond 90 degrees");

  a_vertical_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tilt_from_vertical_o <= 13'd8146))
    else $error("off-vertical word out of range");

endmodule

`default_nettype wire

>>> rtl/core/tca_sqrt_cell.sv
// One bit step of a pipelined integer square root, with a passenger field.
// Stands alone; instantiated in chains by the top level.
`default_nettype none

module tca_sqrt_cell #(
  parameter int unsigned W     = 64,
  parameter int unsigned SW    = 1,
  parameter int unsigned STAGE = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [W-1:0]  rem_i,
  input  wire logic [W-1:0]  root_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [W-1:0]       rem_o,
  output logic [W-1:0]       root_o,
  output logic [SW-1:0]      side_o
);

  // Weight of the root bit that this step decides.
  localparam logic [W-1:0] Bit = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * STAGE);

  logic          valid_q;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  root_q, root_d;
  logic [SW-1:0] side_q;
  logic [W:0]    trial;

  // Subtract the trial value when it fits into the remainder.
  always_comb begin
    trial = {1'b0, root_i} + {1'b0, Bit};
    if ({1'b0, rem_i} >= trial) begin
      rem_d  = rem_i - trial[W-1:0];
      root_d = (root_i >> 1) + Bit;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

>>> rtl/core/tca_cordic_cell.sv
// One CORDIC micro-rotation stage, vectoring or rotation mode, with a passenger field.
// Depends on tca_pkg for the angle type and the arctangent table.
`default_nettype none

module tca_cordic_cell #(
  parameter int unsigned XW     = 36,
  parameter int unsigned SW     = 1,
  parameter int unsigned STAGE  = 0,
  parameter bit          VECTOR = 1'b1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic signed [XW-1:0] x_i,
  input  wire logic signed [XW-1:0] y_i,
  input  wire tca_pkg::ang_t        z_i,
  input  wire logic [SW-1:0]        side_i,
  output logic                      valid_o,
  output logic signed [XW-1:0]      x_o,
  output logic signed [XW-1:0]      y_o,
  output tca_pkg::ang_t             z_o,
  output logic [SW-1:0]             side_o
);

  localparam tca_pkg::ang_t Step = tca_pkg::ATAN_TAB[STAGE];

  logic                 valid_q;
  logic signed [XW-1:0] x_q, x_d, y_q, y_d, dx, dy;
  tca_pkg::ang_t        z_q, z_d;
  logic [SW-1:0]        side_q;
  logic                 cw;

  assign dx = y_i >>> STAGE;
  assign dy = x_i >>> STAGE;

  // Vectoring drives y toward zero; rotation drives z toward zero.
  assign cw = VECTOR ? !y_i[XW-1] : z_i[tca_pkg::AngW-1];

  always_comb begin
    if (cw) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + Step;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - Step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire
